// File: rtl/etp_pkg.sv
// ----------------------------------------------------------------------------
// etp_pkg
// Shared types, constants and the rounding function of the elevation tracker.
// ----------------------------------------------------------------------------
package etp_pkg;

  localparam int ElevWidth  = 12;
  localparam int YearWidth  = 12;
  localparam int SatWidth   = 8;
  localparam int DegWidth   = 8;
  localparam int AddrWidth  = 5;
  localparam int DataWidth  = 32;
  localparam int ElevLimit  = 90;

  typedef logic signed [ElevWidth-1:0] elev_t;
  typedef logic signed [DegWidth-1:0]  deg_t;
  typedef logic [YearWidth-1:0]        year_t;
  typedef logic [SatWidth-1:0]         sat_t;

  typedef enum logic [1:0] {
    TIER_LOW  = 2'd0,
    TIER_MID  = 2'd1,
    TIER_HIGH = 2'd3
  } tier_t;

  typedef enum logic [2:0] {
    REG_YEAR_LOW   = 3'd0,
    REG_YEAR_HIGH  = 3'd1,
    REG_MIN_SATS   = 3'd2,
    REG_LOW_THR    = 3'd3,
    REG_HIGH_THR   = 3'd4
  } reg_idx_t;

  localparam year_t YearLowReset  = 12'd2025;
  localparam year_t YearHighReset = 12'd2035;
  localparam sat_t  MinSatsReset  = 8'd3;
  localparam deg_t  LowThrReset   = 8'sd10;
  localparam deg_t  HighThrReset  = 8'sd20;
  localparam deg_t  DegReset      = 8'sd127;

  typedef struct packed {
    year_t year_low;
    year_t year_high;
    sat_t  min_satellites;
    deg_t  low_threshold;
    deg_t  high_threshold;
  } cfg_t;

  typedef struct packed {
    elev_t elevation_sixteenths;
    logic  time_valid;
    year_t year;
    logic  sats_valid;
    sat_t  satellites_used;
    logic  location_valid;
  } sample_t;

  typedef struct packed {
    logic  fix_ok;
    deg_t  rounded_degrees;
    deg_t  min_degrees;
    deg_t  max_degrees;
    tier_t power_tier;
    logic  rising;
    logic  setting;
    logic  crest;
    logic  trough;
    logic  crest_seen;
    logic  trough_seen;
  } result_t;

  // half away from zero, then clamp to +-90
  function automatic deg_t round_degrees(elev_t e);
    logic [ElevWidth-1:0] mag;
    logic [ElevWidth:0]   sum;
    logic [ElevWidth-4:0] whole;
    logic [DegWidth-2:0]  sat;
    logic [DegWidth-1:0]  pos;
    mag   = e[ElevWidth-1] ? ElevWidth'(-e) : ElevWidth'(e);
    sum   = {1'b0, mag} + (ElevWidth+1)'(8);
    whole = sum[ElevWidth:4];
    sat   = (whole > (ElevWidth-3)'(ElevLimit)) ? (DegWidth-1)'(ElevLimit)
                                                : whole[DegWidth-2:0];
    pos   = {1'b0, sat};
    return e[ElevWidth-1] ? deg_t'(-pos) : deg_t'(pos);
  endfunction

endpackage

// File: rtl/etp_if.sv
// ----------------------------------------------------------------------------
// etp_sample_if / etp_result_if
// Valid-ready channels for samples in and tracker results out.
// ----------------------------------------------------------------------------
interface etp_sample_if import etp_pkg::*; ();
  logic  valid;
  logic  ready;
  elev_t elevation_sixteenths;
  logic  time_valid;
  year_t year;
  logic  sats_valid;
  sat_t  satellites_used;
  logic  location_valid;

  modport source(output valid, elevation_sixteenths, time_valid, year, sats_valid,
                 satellites_used, location_valid, input ready);
  modport sink(input valid, elevation_sixteenths, time_valid, year, sats_valid,
               satellites_used, location_valid, output ready);
endinterface

interface etp_result_if import etp_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  fix_ok;
  deg_t  rounded_degrees;
  deg_t  min_degrees;
  deg_t  max_degrees;
  logic [1:0] power_tier;
  logic  rising;
  logic  setting;
  logic  crest;
  logic  trough;
  logic  crest_seen;
  logic  trough_seen;

  modport source(output valid, fix_ok, rounded_degrees, min_degrees, max_degrees,
                 power_tier, rising, setting, crest, trough, crest_seen,
                 trough_seen, input ready);
  modport sink(input valid, fix_ok, rounded_degrees, min_degrees, max_degrees,
               power_tier, rising, setting, crest, trough, crest_seen,
               trough_seen, output ready);
endinterface

// File: rtl/elevation_trend_peak_tracker.sv
// ----------------------------------------------------------------------------
// elevation_trend_peak_tracker
// Sample and result registers each hold one word; a result is registered from
// the word in the sample register. Throughput: one sample per cycle while the
// result side does not stall. The tracker state updates on a qualified sample
// as the result register loads. Reset (rst, synchronous) empties both registers,
// restores the tracker state and loads the configuration registers with defaults.
// ----------------------------------------------------------------------------
module elevation_trend_peak_tracker import etp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  etp_sample_if.sink           sample,
  etp_result_if.source         result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t    cfg;
  sample_t smp;
  logic    smp_valid;
  result_t res;
  result_t res_q;
  logic    res_valid;
  logic    advance;
  logic    fire;

  etp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  etp_track u_track (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .smp  (smp),
    .fire (fire),
    .res  (res)
  );

  // result slot frees when empty or being taken
  assign advance      = !res_valid || result.ready;
  assign fire         = smp_valid && advance;
  assign sample.ready = !smp_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (sample.ready) begin
        smp_valid <= sample.valid;
      end
      if (advance) begin
        res_valid <= smp_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      smp.elevation_sixteenths <= sample.elevation_sixteenths;
      smp.time_valid           <= sample.time_valid;
      smp.year                 <= sample.year;
      smp.sats_valid           <= sample.sats_valid;
      smp.satellites_used      <= sample.satellites_used;
      smp.location_valid       <= sample.location_valid;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign result.valid           = res_valid;
  assign result.fix_ok          = res_q.fix_ok;
  assign result.rounded_degrees = res_q.rounded_degrees;
  assign result.min_degrees     = res_q.min_degrees;
  assign result.max_degrees     = res_q.max_degrees;
  assign result.power_tier      = res_q.power_tier;
  assign result.rising          = res_q.rising;
  assign result.setting         = res_q.setting;
  assign result.crest           = res_q.crest;
  assign result.trough          = res_q.trough;
  assign result.crest_seen      = res_q.crest_seen;
  assign result.trough_seen     = res_q.trough_seen;

endmodule

// File: rtl/etp_cfg.sv
// ----------------------------------------------------------------------------
// etp_cfg
// APB register file holding the fix year window, the minimum satellite count and
// the power tier thresholds.
module etp_cfg import etp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.year_low       <= YearLowReset;
      regs.year_high      <= YearHighReset;
      regs.min_satellites <= MinSatsReset;
      regs.low_threshold  <= LowThrReset;
      regs.high_threshold <= HighThrReset;
    end else if (wr) begin
      unique case (idx)
        REG_YEAR_LOW:  regs.year_low       <= pwdata[YearWidth-1:0];
        REG_YEAR_HIGH: regs.year_high      <= pwdata[YearWidth-1:0];
        REG_MIN_SATS:  regs.min_satellites <= pwdata[SatWidth-1:0];
        REG_LOW_THR:   regs.low_threshold  <= deg_t'(pwdata[DegWidth-1:0]);
        REG_HIGH_THR:  regs.high_threshold <= deg_t'(pwdata[DegWidth-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_YEAR_LOW:  prdata = DataWidth'(regs.year_low);
      REG_YEAR_HIGH: prdata = DataWidth'(regs.year_high);
      REG_MIN_SATS:  prdata = DataWidth'(regs.min_satellites);
      REG_LOW_THR:   prdata = DataWidth'(regs.low_threshold);
      REG_HIGH_THR:  prdata = DataWidth'(regs.high_threshold);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: rtl/etp_track.sv
// ----------------------------------------------------------------------------
// etp_track
// Fix qualification, rounding, min/max, power tier, trend and crest/trough state.
// ----------------------------------------------------------------------------
module etp_track import etp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  sample_t smp,
  input  logic    fire,
  output result_t res
);

  logic  started;
  deg_t  previous_degrees;
  deg_t  lowest_degrees;
  deg_t  highest_degrees;
  logic  was_rising;
  logic  was_setting;
  logic  crest_flag_kept;
  logic  trough_flag_kept;
  tier_t tier_kept;

  logic  ok;
  deg_t  r;
  deg_t  lowest_next;
  deg_t  highest_next;
  tier_t tier_next;
  logic  rise;
  logic  fall;
  logic  crest;
  logic  trough;

  assign ok = smp.time_valid && smp.year >= cfg.year_low && smp.year <= cfg.year_high &&
              smp.sats_valid && smp.satellites_used >= cfg.min_satellites &&
              smp.location_valid;
  assign r  = round_degrees(smp.elevation_sixteenths);

  always_comb begin
    lowest_next  = (!started || r < lowest_degrees) ? r : lowest_degrees;
    highest_next = (!started || r > highest_degrees) ? r : highest_degrees;
    priority if (r < cfg.low_threshold) begin
      tier_next = TIER_LOW;
    end else if (r < cfg.high_threshold) begin
      tier_next = TIER_MID;
    end else begin
      tier_next = TIER_HIGH;
    end
    // first qualified sample counts as rising
    rise   = !started || r > previous_degrees;
    fall   = started && r < previous_degrees;
    crest  = fall && was_rising;
    trough = started && r > previous_degrees && was_setting;

    res.fix_ok          = ok;
    res.rounded_degrees = ok ? r : '0;
    res.min_degrees     = ok ? lowest_next : lowest_degrees;
    res.max_degrees     = ok ? highest_next : highest_degrees;
    res.power_tier      = ok ? tier_next : tier_kept;
    res.rising          = ok && rise;
    res.setting         = ok && fall;
    res.crest           = ok && crest;
    res.trough          = ok && trough;
    res.crest_seen      = crest_flag_kept || (ok && crest);
    res.trough_seen     = trough_flag_kept || (ok && trough);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= 1'b0;
      previous_degrees <= DegReset;
      lowest_degrees   <= DegReset;
      highest_degrees  <= DegReset;
      was_rising       <= 1'b0;
      was_setting      <= 1'b0;
      crest_flag_kept  <= 1'b0;
      trough_flag_kept <= 1'b0;
      tier_kept        <= TIER_HIGH;
    end else if (fire && ok) begin
      started          <= 1'b1;
      previous_degrees <= r;
      lowest_degrees   <= lowest_next;
      highest_degrees  <= highest_next;
      was_rising       <= rise;
      was_setting      <= fall;
      crest_flag_kept  <= res.crest_seen;
      trough_flag_kept <= res.trough_seen;
      tier_kept        <= tier_next;
    end
  end

endmodule
